// File: rtl/sactl_pkg.sv
// ----------------------------------------------------------------------------
// sactl_pkg
// Shared types and constants of the set-associative cache tag lookup.
// ----------------------------------------------------------------------------
package sactl_pkg;

  localparam int DEF_SET_COUNT = 64;
  localparam int DEF_WAYS      = 4;

  localparam int ADDR_W   = 32;
  localparam int STAMP_W  = 32;
  localparam int CNT_W    = 32;
  localparam int MAX_SHIFT = 12;

  localparam logic REQ_ACCESS = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_LRU  = 2'd1;
  localparam logic [1:0] POL_WAY0 = 2'd2;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_OFFSET = 1'b1;

  localparam logic [1:0] POLICY_RESET = POL_LRU;
  localparam logic [3:0] OFFSET_RESET = 4'd6;

  typedef struct packed {
    logic [1:0] policy;
    logic [3:0] offset;
  } cfg_t;

  typedef struct packed {
    logic sweeping;
  } back_stat_t;

endpackage

// File: rtl/sactl_fifo.sv
// ----------------------------------------------------------------------------
// sactl_fifo
// Two-entry queue between the front and the back of the lookup.
// ----------------------------------------------------------------------------
module sactl_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  logic [WIDTH-1:0] ent_r [2];
  logic             rd_ptr_r, rd_ptr_nxt;
  logic             wr_ptr_r, wr_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end
endmodule

// File: rtl/sactl_front.sv
// ----------------------------------------------------------------------------
// sactl_front
// Accepts words, strips the block offset and splits set index from tag.
// ----------------------------------------------------------------------------
module sactl_front #(
  parameter int SET_COUNT = 64,
  parameter int SET_W     = 6,
  parameter int TAG_W     = 26
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sactl_pkg::cfg_t            cfg,
  input  sactl_pkg::back_stat_t      stat,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [sactl_pkg::ADDR_W-1:0] in_addr,
  input  logic                       in_kind,
  output logic                       q_valid,
  input  logic                       q_ready,
  output logic [TAG_W+SET_W:0]       q_data
);
  import sactl_pkg::*;

  localparam bit POW2 = (SET_COUNT & (SET_COUNT - 1)) == 0;
  localparam int LOG2 = $clog2(SET_COUNT);

  logic [3:0]        shift;
  logic [ADDR_W-1:0] block;

  always_comb begin
    shift = (cfg.offset > 4'(MAX_SHIFT)) ? 4'(MAX_SHIFT) : cfg.offset;
    block = in_addr >> shift;
  end

  generate
    if (POW2) begin : g_pow2
      logic [SET_W-1:0] set_idx;
      if (SET_COUNT > 1) begin : g_set
        assign set_idx = block[SET_W-1:0];
      end else begin : g_one
        assign set_idx = '0;
      end
      assign in_tready = q_ready && !stat.sweeping;
      assign q_valid   = in_tvalid && !stat.sweeping;
      assign q_data    = {in_kind, set_idx, TAG_W'(block >> LOG2)};
    end else begin : g_div
      // The quotient is the top of block * (2^32 + RECIP_LO), which is exact
      // for every 32-bit block; the remainder follows from it.
      localparam longint unsigned RECIP =
        ((64'd1 << (ADDR_W + LOG2)) / 64'(SET_COUNT)) + 64'd1;
      localparam logic [ADDR_W-1:0] RECIP_LO = ADDR_W'(RECIP);

      typedef enum logic [2:0] {DV_IDLE, DV_MUL, DV_QUO, DV_REM, DV_DONE} div_state_t;

      div_state_t          dv_r, dv_nxt;
      logic [ADDR_W-1:0]   blk_r, blk_nxt;
      logic [2*ADDR_W-1:0] prod_r, prod_nxt;
      logic [ADDR_W-1:0]   quo_r, quo_nxt;
      logic [SET_W-1:0]    rem_r, rem_nxt;
      logic [2*ADDR_W:0]   full_prod;
      logic [ADDR_W-1:0]   back_mul;

      assign in_tready = (dv_r == DV_IDLE) && q_ready && !stat.sweeping;
      assign q_valid   = (dv_r == DV_DONE) ||
                         ((dv_r == DV_IDLE) && in_tvalid && in_kind == REQ_CLEAR &&
                          !stat.sweeping);
      assign q_data    = (dv_r == DV_DONE) ? {REQ_ACCESS, rem_r, TAG_W'(quo_r)}
                                           : {REQ_CLEAR, {(SET_W + TAG_W){1'b0}}};
      assign full_prod = {1'b0, blk_r, {ADDR_W{1'b0}}} + {1'b0, prod_r};
      assign back_mul  = quo_r * ADDR_W'(SET_COUNT);

      always_comb begin
        dv_nxt   = dv_r;
        blk_nxt  = blk_r;
        prod_nxt = prod_r;
        quo_nxt  = quo_r;
        rem_nxt  = rem_r;
        case (dv_r)
          DV_IDLE: begin
            if (in_tvalid && in_tready && in_kind == REQ_ACCESS) begin
              blk_nxt = block;
              dv_nxt  = DV_MUL;
            end
          end
          DV_MUL: begin
            prod_nxt = (2*ADDR_W)'(blk_r) * (2*ADDR_W)'(RECIP_LO);
            dv_nxt   = DV_QUO;
          end
          DV_QUO: begin
            quo_nxt = ADDR_W'(full_prod >> (ADDR_W + LOG2));
            dv_nxt  = DV_REM;
          end
          DV_REM: begin
            rem_nxt = SET_W'(blk_r - back_mul);
            dv_nxt  = DV_DONE;
          end
          DV_DONE: begin
            if (q_ready) dv_nxt = DV_IDLE;
          end
          default: dv_nxt = DV_IDLE;
        endcase
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_r <= DV_IDLE;
        end else begin
          dv_r <= dv_nxt;
        end
        blk_r  <= blk_nxt;
        prod_r <= prod_nxt;
        quo_r  <= quo_nxt;
        rem_r  <= rem_nxt;
      end
    end
  endgenerate
endmodule

// File: rtl/sactl_back.sv
// ----------------------------------------------------------------------------
// sactl_back
// Set memory, hit check, victim choice, write-back, counters and output.
// ----------------------------------------------------------------------------
module sactl_back #(
  parameter int SET_COUNT = 64,
  parameter int WAYS      = 4,
  parameter int SET_W     = 6,
  parameter int TAG_W     = 26
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sactl_pkg::cfg_t       cfg,
  output sactl_pkg::back_stat_t stat,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic [TAG_W+SET_W:0]  q_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [71:0]           out_tdata
);
  import sactl_pkg::*;

  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TB    = WAYS;
  localparam int SB    = WAYS + WAYS * TAG_W;
  localparam int ROW_W = SB + WAYS * STAMP_W;

  typedef enum logic [2:0] {ST_SWEEP, ST_IDLE, ST_LOOK, ST_SCAN, ST_EMIT} state_t;

  logic [ROW_W-1:0] mem [SET_COUNT];
  logic [ROW_W-1:0] rdata_r;

  state_t           state_r, state_nxt;
  logic [SET_W-1:0] sw_r, sw_nxt;
  logic             clr_res_r, clr_res_nxt;
  logic [SET_W-1:0] set_r, set_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic [STAMP_W-1:0] clock_r, clock_nxt;
  logic [CNT_W-1:0] hits_r, hits_nxt, miss_r, miss_nxt;
  logic             hit_r, hit_nxt;
  logic [WW-1:0]    way_r, way_nxt;
  logic [WW-1:0]    scan_r, scan_nxt;
  logic [WW-1:0]    best_r, best_nxt;
  logic [STAMP_W-1:0] oldest_r, oldest_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [71:0]      out_data_r, out_data_nxt;

  logic             q_clear;
  logic [SET_W-1:0] q_set;
  logic [TAG_W-1:0] q_tag;
  logic             rd_en;
  logic             we;
  logic [SET_W-1:0] wa;
  logic [ROW_W-1:0] wd;
  logic             any_hit, any_inv;
  logic [WW-1:0]    hit_way, inv_way;
  logic [STAMP_W-1:0] cand;
  logic [WW-1:0]    scan_best;
  logic             upd_en;
  logic [WW-1:0]    upd_way;
  logic             upd_fill;

  assign {q_clear, q_set, q_tag} = q_data;
  assign stat.sweeping = (state_r == ST_SWEEP);
  assign q_ready    = (state_r == ST_IDLE);
  assign rd_en      = (state_r == ST_IDLE) && q_valid && (q_clear == REQ_ACCESS);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Lowest matching way and lowest invalid way of the row just read.
  always_comb begin
    any_hit = 1'b0;
    any_inv = 1'b0;
    hit_way = '0;
    inv_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rdata_r[w] && rdata_r[TB + w * TAG_W +: TAG_W] == tag_r) begin
        any_hit = 1'b1;
        hit_way = WW'(w);
      end
      if (!rdata_r[w]) begin
        any_inv = 1'b1;
        inv_way = WW'(w);
      end
    end
  end

  assign cand      = rdata_r[SB + scan_r * STAMP_W +: STAMP_W];
  assign scan_best = (cand < oldest_r) ? scan_r : best_r;

  always_comb begin
    state_nxt     = state_r;
    sw_nxt        = sw_r;
    clr_res_nxt   = clr_res_r;
    set_nxt       = set_r;
    tag_nxt       = tag_r;
    clock_nxt     = clock_r;
    hits_nxt      = hits_r;
    miss_nxt      = miss_r;
    hit_nxt       = hit_r;
    way_nxt       = way_r;
    scan_nxt      = scan_r;
    best_nxt      = best_r;
    oldest_nxt    = oldest_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    upd_en        = 1'b0;
    upd_way       = '0;
    upd_fill      = 1'b0;
    we            = 1'b0;
    wa            = set_r;
    case (state_r)
      ST_SWEEP: begin
        we = 1'b1;
        wa = sw_r;
        sw_nxt = sw_r + SET_W'(1);
        if (sw_r == SET_W'(SET_COUNT - 1)) begin
          sw_nxt    = '0;
          state_nxt = clr_res_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          if (q_clear == REQ_CLEAR) begin
            clr_res_nxt = 1'b1;
            clock_nxt   = '0;
            hits_nxt    = '0;
            miss_nxt    = '0;
            hit_nxt     = 1'b0;
            way_nxt     = '0;
            sw_nxt      = '0;
            state_nxt   = ST_SWEEP;
          end else begin
            set_nxt   = q_set;
            tag_nxt   = q_tag;
            clock_nxt = clock_r + STAMP_W'(1);
            state_nxt = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        clr_res_nxt = 1'b0;
        if (any_hit) begin
          hit_nxt = 1'b1;
          way_nxt = hit_way;
          if (hits_r != '1) hits_nxt = hits_r + CNT_W'(1);
          upd_en    = (cfg.policy == POL_LRU);
          upd_way   = hit_way;
          state_nxt = ST_EMIT;
        end else begin
          hit_nxt = 1'b0;
          if (miss_r != '1) miss_nxt = miss_r + CNT_W'(1);
          if (any_inv) begin
            upd_en = 1'b1; upd_fill = 1'b1; upd_way = inv_way;
            way_nxt = inv_way;
            state_nxt = ST_EMIT;
          end else if (WAYS > 1 && (cfg.policy == POL_FIFO || cfg.policy == POL_LRU)) begin
            scan_nxt   = WW'(1);
            best_nxt   = '0;
            oldest_nxt = rdata_r[SB +: STAMP_W];
            state_nxt  = ST_SCAN;
          end else begin
            upd_en = 1'b1; upd_fill = 1'b1; upd_way = '0;
            way_nxt = '0;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        // One way of the full set is checked per cycle for the oldest stamp.
        best_nxt   = scan_best;
        oldest_nxt = (cand < oldest_r) ? cand : oldest_r;
        scan_nxt   = scan_r + WW'(1);
        if (scan_r == WW'(WAYS - 1)) begin
          upd_en = 1'b1; upd_fill = 1'b1; upd_way = scan_best;
          way_nxt = scan_best;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, miss_r, hits_r, 2'(way_r), hit_r};
          clr_res_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (upd_en) we = 1'b1;
  end

  always_comb begin
    wd = rdata_r;
    if (state_r == ST_SWEEP) begin
      wd = '0;
    end else if (upd_fill) begin
      wd[upd_way] = 1'b1;
      wd[TB + upd_way * TAG_W +: TAG_W] = tag_r;
      wd[SB + upd_way * STAMP_W +: STAMP_W] = clock_r;
    end else begin
      wd[SB + upd_way * STAMP_W +: STAMP_W] = clock_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_en) rdata_r <= mem[q_set];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sw_r        <= '0;
      clr_res_r   <= 1'b0;
      clock_r     <= '0;
      hits_r      <= '0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sw_r        <= sw_nxt;
      clr_res_r   <= clr_res_nxt;
      clock_r     <= clock_nxt;
      hits_r      <= hits_nxt;
      miss_r      <= miss_nxt;
      out_valid_r <= out_valid_nxt;
    end
    set_r      <= set_nxt;
    tag_r      <= tag_nxt;
    hit_r      <= hit_nxt;
    way_r      <= way_nxt;
    scan_r     <= scan_nxt;
    best_r     <= best_nxt;
    oldest_r   <= oldest_nxt;
    out_data_r <= out_data_nxt;
  end
endmodule

// File: rtl/set_assoc_cache_tag_lookup_top.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_top
// Tag store of a set-associative cache with FIFO, LRU or way-zero refill.
// ----------------------------------------------------------------------------
// Usage: each input word carries a byte address in in_tdata and the request
// kind in in_tuser (access or clear). Every word yields one output word with
// the hit flag, the way, and the saturating hit and miss counts.
// The front strips the block offset and splits set and tag; with a set count
// that is a power of two this is immediate, otherwise a reciprocal multiply
// runs through DV_MUL, DV_QUO and DV_REM, and the front takes no new access
// until the last has left DV_DONE. A two-word queue decouples it from the back.
// The back reads the set row from a synchronous memory, checks all ways,
// writes the row back on a fill or an LRU hit and loads the output register;
// it steps through ST_IDLE, ST_LOOK and ST_EMIT, with ST_SCAN between on a
// miss into a full set under FIFO or LRU, where the oldest stamp is searched
// one way per cycle.
// A clear word sweeps the memory one set per cycle.
// After reset the same sweep runs with in_tready low; configuration writes
// are taken at any time.
// When the receiver stalls, the output register holds its word and the back
// still finishes the next lookup before it waits; the queue then fills and
// in_tready drops.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup_top #(
  parameter int SET_COUNT = sactl_pkg::DEF_SET_COUNT,
  parameter int WAYS      = sactl_pkg::DEF_WAYS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] address
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [0] hit, [2:1] way, [34:3] hit_count,
                                  // [66:35] miss_count, rest zero
);
  import sactl_pkg::*;

  localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int TAG_W = 33 - $clog2(SET_COUNT + 1);

  cfg_t       cfg_r, cfg_nxt;
  back_stat_t stat;
  logic       q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  logic [TAG_W+SET_W:0] q_in_data, q_out_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_POLICY: cfg_nxt.policy = cfg_wdata[1:0];
        CFG_OFFSET: cfg_nxt.offset = cfg_wdata;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.policy <= POLICY_RESET;
      cfg_r.offset <= OFFSET_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sactl_front #(
    .SET_COUNT(SET_COUNT), .SET_W(SET_W), .TAG_W(TAG_W)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .stat(stat),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_addr(in_tdata), .in_kind(in_tuser),
    .q_valid(q_in_valid), .q_ready(q_in_ready), .q_data(q_in_data)
  );

  sactl_fifo #(
    .WIDTH(TAG_W + SET_W + 1)
  ) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push_valid(q_in_valid), .push_ready(q_in_ready), .push_data(q_in_data),
    .pop_valid(q_out_valid), .pop_ready(q_out_ready), .pop_data(q_out_data)
  );

  sactl_back #(
    .SET_COUNT(SET_COUNT), .WAYS(WAYS), .SET_W(SET_W), .TAG_W(TAG_W)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .stat(stat),
    .q_valid(q_out_valid), .q_ready(q_out_ready), .q_data(q_out_data),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );
endmodule
